@@ sv/lts_pkg.sv @@
// shared types, token codes and character tables for the lexical token scanner
package lts_pkg;

   localparam int MAX_LEXEME  = 16;
   localparam int STORE_DEPTH = 16;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int LEN_W       = 5;
   localparam int KW_COUNT    = 8;
   localparam int KW_BYTES    = 5;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEXEME);

   // token kinds
   localparam logic [4:0] KIND_ADD    = 5'd0;
   localparam logic [4:0] KIND_SUB    = 5'd1;
   localparam logic [4:0] KIND_MUL    = 5'd2;
   localparam logic [4:0] KIND_DIV    = 5'd3;
   localparam logic [4:0] KIND_AND    = 5'd4;
   localparam logic [4:0] KIND_OR     = 5'd5;
   localparam logic [4:0] KIND_LBRACE = 5'd6;
   localparam logic [4:0] KIND_RBRACE = 5'd7;
   localparam logic [4:0] KIND_SEMI   = 5'd8;
   localparam logic [4:0] KIND_LPAREN = 5'd9;
   localparam logic [4:0] KIND_RPAREN = 5'd10;
   localparam logic [4:0] KIND_RELOP  = 5'd11;
   localparam logic [4:0] KIND_ASSIGN = 5'd12;
   localparam logic [4:0] KIND_INT    = 5'd13;
   localparam logic [4:0] KIND_ID     = 5'd21;
   localparam logic [4:0] KIND_NUMBER = 5'd22;
   localparam logic [4:0] KIND_ERROR  = 5'd23;

   // characters
   localparam logic [7:0] CH_EOL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // keywords, first character in the lowest byte
   localparam logic [8*KW_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
      40'h000074_6E69,   // int
      40'h0000006669,    // if
      40'h006E656874,    // then
      40'h0065736C65,    // else
      40'h656C696877,    // while
      40'h0000006F64,    // do
      40'h0064616572,    // read
      40'h6574697277     // write
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      5'd3, 5'd2, 5'd4, 5'd4, 5'd5, 5'd2, 5'd4, 5'd5
   };

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_WORD   = 5'b00010,
      MODE_NUMBER = 5'b00100,
      MODE_REL    = 5'b01000,
      MODE_EQ     = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [4:0]       kind;
      logic [63:0]      text_first;
      logic [63:0]      text_second;
      logic [LEN_W-1:0] text_length;
      logic             truncated;
      logic             last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // {hit, kind} for single-character operators and brackets
   function automatic logic [5:0] op_lookup(input logic [7:0] c);
      logic [5:0] res;
      unique case (c)
         CH_PLUS:   res = {1'b1, KIND_ADD};
         CH_MINUS:  res = {1'b1, KIND_SUB};
         CH_STAR:   res = {1'b1, KIND_MUL};
         CH_SLASH:  res = {1'b1, KIND_DIV};
         CH_AMP:    res = {1'b1, KIND_AND};
         CH_BAR:    res = {1'b1, KIND_OR};
         CH_LBRACE: res = {1'b1, KIND_LBRACE};
         CH_RBRACE: res = {1'b1, KIND_RBRACE};
         CH_SEMI:   res = {1'b1, KIND_SEMI};
         CH_LPAREN: res = {1'b1, KIND_LPAREN};
         CH_RPAREN: res = {1'b1, KIND_RPAREN};
         default:   res = 6'd0;
      endcase
      return res;
   endfunction

   // {hit, keyword index} for a finished word
   function automatic logic [3:0] kw_lookup(input logic [8*KW_BYTES-1:0] head,
                                            input logic [LEN_W-1:0] len);
      logic [3:0] res;
      logic       same;
      res = 4'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         same = (len == KW_LEN[k]);
         for (int b = 0; b < KW_BYTES; b++) begin
            if (LEN_W'(b) < KW_LEN[k] && head[8*b +: 8] != KW_TEXT[k][8*b +: 8]) begin
               same = 1'b0;
            end
         end
         if (same && !res[3]) begin
            res = {1'b1, 3'(k)};
         end
      end
      return res;
   endfunction

endpackage

@@ sv/lts_scan.sv @@
// input register, scanner mode and lexeme store, and the per-character token logic
module lts_scan (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_character,
   input  logic [1:0]       free,
   output lts_pkg::push_type push
);
   import lts_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       char_ff;
   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       store_ff [STORE_DEPTH];

   logic [7:0]          c;
   logic                letter, digit, is_rel, is_eq, blank, invalid, op_hit;
   logic [4:0]          op_kind;
   logic                cont, finish, close_pair, rescan, idle_emit, start;
   logic [1:0]          need;
   logic                fire;
   logic [3:0]          kw;
   logic [8*STORE_DEPTH-1:0] lex_text;
   logic [8*KW_BYTES-1:0]    lex_head;
   token_type           fin_tok, idle_tok;
   logic                store_we;
   logic [STORE_AW-1:0] store_addr;

   assign c = char_ff;

   // character classes
   always_comb begin
      letter  = is_letter(c);
      digit   = is_digit(c);
      {op_hit, op_kind} = op_lookup(c);
      is_rel  = (c == CH_LT) || (c == CH_GT) || (c == CH_BANG);
      is_eq   = (c == CH_EQ);
      blank   = (c == CH_SPACE) || (c == CH_EOL);
      invalid = !(letter || digit || op_hit || is_rel || is_eq || blank);
   end

   always_comb begin
      unique case (mode_ff)
         MODE_WORD: begin
            cont   = letter || digit;
            finish = !(letter || digit);
         end
         MODE_NUMBER: begin
            cont   = digit;
            finish = !digit;
         end
         MODE_REL, MODE_EQ: begin
            cont   = 1'b0;
            finish = 1'b1;
         end
         default: begin
            cont   = 1'b0;
            finish = 1'b0;
         end
      endcase
      close_pair = (mode_ff == MODE_REL || mode_ff == MODE_EQ) && is_eq;
      rescan     = !cont && !close_pair;
      idle_emit  = rescan && (op_hit || invalid);
      start      = rescan && (letter || digit || is_rel || is_eq);
      need       = 2'(finish) + 2'(idle_emit);
   end

   // stored text, zero beyond the current length
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         lex_text[8*i +: 8] = (LEN_W'(i) < len_ff) ? store_ff[i] : 8'd0;
      end
      lex_head = lex_text[8*KW_BYTES-1:0];
      kw       = kw_lookup(lex_head, len_ff);
   end

   // token that closes the pending lexeme
   always_comb begin
      fin_tok = '0;
      unique case (mode_ff)
         MODE_WORD: begin
            if (kw[3] && !ovf_ff) begin
               fin_tok.kind = 5'(KIND_INT + {2'd0, kw[2:0]});
            end else begin
               fin_tok.kind        = KIND_ID;
               fin_tok.text_first  = lex_text[63:0];
               fin_tok.text_second = lex_text[127:64];
               fin_tok.text_length = len_ff;
               fin_tok.truncated   = ovf_ff;
            end
         end
         MODE_NUMBER: begin
            fin_tok.kind        = KIND_NUMBER;
            fin_tok.text_first  = lex_text[63:0];
            fin_tok.text_second = lex_text[127:64];
            fin_tok.text_length = len_ff;
            fin_tok.truncated   = ovf_ff;
         end
         MODE_REL, MODE_EQ: begin
            if (close_pair) begin
               fin_tok.kind        = KIND_RELOP;
               fin_tok.text_first  = {48'd0, CH_EQ, store_ff[0]};
               fin_tok.text_length = 5'd2;
            end else if (mode_ff == MODE_EQ) begin
               fin_tok.kind = KIND_ASSIGN;
            end else begin
               // lone bang is emitted as an error token
               fin_tok.kind        = (store_ff[0] == CH_BANG) ? KIND_ERROR : KIND_RELOP;
               fin_tok.text_first  = {56'd0, store_ff[0]};
               fin_tok.text_length = 5'd1;
            end
         end
         default: begin
            fin_tok = '0;
         end
      endcase
      fin_tok.last = !idle_emit;
   end

   // token from scanning the character itself
   always_comb begin
      idle_tok = '0;
      if (op_hit) begin
         idle_tok.kind = op_kind;
      end else begin
         idle_tok.kind        = KIND_ERROR;
         idle_tok.text_first  = {56'd0, c};
         idle_tok.text_length = 5'd1;
      end
      idle_tok.last = 1'b1;
   end

   assign fire      = in_valid_ff && (need <= free);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      push.count  = fire ? need : 2'd0;
      push.first  = finish ? fin_tok : idle_tok;
      push.second = idle_tok;
   end

   // next scanner state
   always_comb begin
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);
      mode_in     = mode_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      store_we    = 1'b0;
      store_addr  = len_ff[STORE_AW-1:0];
      if (fire) begin
         if (cont) begin
            if (len_ff < MAX_LEN) begin
               store_we = 1'b1;
               len_in   = len_ff + 5'd1;
            end else begin
               ovf_in = 1'b1;
            end
         end else if (start) begin
            store_we   = 1'b1;
            store_addr = '0;
            len_in     = 5'd1;
            ovf_in     = 1'b0;
            priority if (letter) begin
               mode_in = MODE_WORD;
            end else if (digit) begin
               mode_in = MODE_NUMBER;
            end else if (is_rel) begin
               mode_in = MODE_REL;
            end else begin
               mode_in = MODE_EQ;
            end
         end else begin
            mode_in = MODE_IDLE;
            len_in  = 5'd0;
            ovf_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         len_ff      <= 5'd0;
         ovf_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         len_ff      <= len_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_character;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_addr] <= c;
      end
   end

endmodule

@@ sv/lts_rsp_queue.sv @@
// two-entry result queue that takes up to two tokens per cycle
module lts_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  lts_pkg::push_type push,
   output logic [1:0]        free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lts_pkg::token_type rsp_token
);
   import lts_pkg::*;

   token_type  slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       head_ff, head_in;
   logic       tail;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_token = slot_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign free      = 2'd2 - count_ff;
   assign tail      = head_ff ^ count_ff[0];
   assign count_in  = count_ff - 2'(pop) + push.count;
   assign head_in   = head_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[tail] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[!tail] <= push.second;
      end
   end

endmodule

@@ sv/lexical_token_scanner.sv @@
// path: a character's tokens pass through the character register, then the result queue
// throughput: one character per cycle while the result queue has room for its tokens; a
//   character that yields two tokens holds up the next input, as the queue drains one token per cycle
// reset: synchronous, active high; scanner returns to idle, lexeme length and
//   overflow flag clear, result queue empties; lexeme bytes are not cleared
module lexical_token_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_kind,
   output logic [63:0] rsp_text_first,
   output logic [63:0] rsp_text_second,
   output logic [4:0]  rsp_text_length,
   output logic        rsp_truncated,
   output logic        rsp_last
);
   import lts_pkg::*;

   // tokens produced by one character, towards the queue
   push_type   push;
   // free queue entries, registered count only so input ready never waits on rsp_ready
   logic [1:0] free;
   token_type  rsp_token;

   // character register, scanner mode, lexeme store and token decode
   lts_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_character (req_character),
      .free          (free),
      .push          (push)
   );

   // result registers: parts the input side from a stalled consumer
   lts_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_token (rsp_token)
   );

   // unpack the head token onto the result ports
   assign rsp_kind        = rsp_token.kind;
   assign rsp_text_first  = rsp_token.text_first;
   assign rsp_text_second = rsp_token.text_second;
   assign rsp_text_length = rsp_token.text_length;
   assign rsp_truncated   = rsp_token.truncated;
   assign rsp_last        = rsp_token.last;

endmodule

@@ sv/lts_checker.sv @@
// port-level checks for the lexical token scanner, bound to the top level
module lts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_kind,
   input logic [63:0] rsp_text_first,
   input logic [63:0] rsp_text_second,
   input logic [4:0]  rsp_text_length,
   input logic        rsp_truncated,
   input logic        rsp_last
);
   import lts_pkg::*;

   logic fixed_kind;
   assign fixed_kind = rsp_kind != KIND_RELOP && rsp_kind != KIND_ID &&
                       rsp_kind != KIND_NUMBER && rsp_kind != KIND_ERROR;

   // nothing offered straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_text_first) && $stable(rsp_text_second) &&
      $stable(rsp_text_length) && $stable(rsp_truncated) && $stable(rsp_last))
      else $error("stalled result changed");

   // truncation only on full-length identifiers and numbers
   a_truncated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |->
      rsp_text_length == MAX_LEN && (rsp_kind == KIND_ID || rsp_kind == KIND_NUMBER))
      else $error("bad truncation flag");

   // operators, brackets, assignment and keywords carry no text
   a_fixed_no_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fixed_kind |->
      rsp_text_length == 5'd0 && !rsp_truncated &&
      rsp_text_first == 64'd0 && rsp_text_second == 64'd0)
      else $error("fixed token carries text");

   // the input side only refuses a transaction while results are waiting
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind lexical_token_scanner lts_checker u_lts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_text_first  (rsp_text_first),
   .rsp_text_second (rsp_text_second),
   .rsp_text_length (rsp_text_length),
   .rsp_truncated   (rsp_truncated),
   .rsp_last        (rsp_last)
);

@@ test/lts_token_checker.sv @@
// token checker for the lexical token scanner: predicts each character's tokens and compares
module lts_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_kind,
   input  logic [63:0] rsp_text_first,
   input  logic [63:0] rsp_text_second,
   input  logic [4:0]  rsp_text_length,
   input  logic        rsp_truncated,
   input  logic        rsp_last,
   output int unsigned failure_count,
   output int unsigned tokens_pending
);
   import lts_pkg::*;

   mode_type    scan_mode;
   logic [7:0]  lexeme_bytes [STORE_DEPTH];
   int unsigned lexeme_len;
   logic        lexeme_cut;
   token_type   char_tokens [$];
   token_type   expected_tokens [$];
   int unsigned token_count;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic string keyword_word(input int k);
      string w;
      case (k)
         0: w = "int";
         1: w = "if";
         2: w = "then";
         3: w = "else";
         4: w = "while";
         5: w = "do";
         6: w = "read";
         default: w = "write";
      endcase
      return w;
   endfunction

   function automatic void append_char(input logic [7:0] c);
      if (lexeme_len < MAX_LEXEME) begin
         lexeme_bytes[lexeme_len] = c;
         lexeme_len++;
      end else begin
         lexeme_cut = 1'b1;
      end
   endfunction

   function automatic void begin_lexeme(input logic [7:0] c);
      lexeme_len = 0;
      lexeme_cut = 1'b0;
      append_char(c);
   endfunction

   function automatic void emit_token(input logic [4:0] kind, input logic with_text);
      token_type t;
      t = '0;
      t.kind = kind;
      if (with_text) begin
         for (int i = 0; i < lexeme_len; i++) begin
            if (i < 8) t.text_first[8*i +: 8] = lexeme_bytes[i];
            else t.text_second[8*(i-8) +: 8] = lexeme_bytes[i];
         end
         t.text_length = LEN_W'(lexeme_len);
         t.truncated = lexeme_cut;
         lexeme_len = 0;
         lexeme_cut = 1'b0;
      end
      char_tokens = {char_tokens, t};
   endfunction

   // a cut word is always an identifier
   function automatic void finish_word();
      string w;
      logic  same;
      if (!lexeme_cut) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            w = keyword_word(k);
            same = (w.len() == lexeme_len);
            for (int i = 0; i < w.len() && same; i++) begin
               if (lexeme_bytes[i] != w[i]) same = 1'b0;
            end
            if (same) begin
               lexeme_len = 0;
               emit_token(KIND_INT + 5'(k), 1'b0);
               return;
            end
         end
      end
      emit_token(KIND_ID, 1'b1);
   endfunction

   function automatic void scan_start(input logic [7:0] c);
      scan_mode = MODE_IDLE;
      if (is_alpha(c)) begin
         begin_lexeme(c);
         scan_mode = MODE_WORD;
      end else if (is_numeral(c)) begin
         begin_lexeme(c);
         scan_mode = MODE_NUMBER;
      end else begin
         case (c)
            CH_PLUS:   emit_token(KIND_ADD, 1'b0);
            CH_MINUS:  emit_token(KIND_SUB, 1'b0);
            CH_STAR:   emit_token(KIND_MUL, 1'b0);
            CH_SLASH:  emit_token(KIND_DIV, 1'b0);
            CH_AMP:    emit_token(KIND_AND, 1'b0);
            CH_BAR:    emit_token(KIND_OR, 1'b0);
            CH_LBRACE: emit_token(KIND_LBRACE, 1'b0);
            CH_RBRACE: emit_token(KIND_RBRACE, 1'b0);
            CH_SEMI:   emit_token(KIND_SEMI, 1'b0);
            CH_LPAREN: emit_token(KIND_LPAREN, 1'b0);
            CH_RPAREN: emit_token(KIND_RPAREN, 1'b0);
            CH_LT, CH_GT, CH_BANG: begin
               begin_lexeme(c);
               scan_mode = MODE_REL;
            end
            CH_EQ: begin
               begin_lexeme(c);
               scan_mode = MODE_EQ;
            end
            CH_SPACE, CH_EOL: ;
            default: begin
               begin_lexeme(c);
               emit_token(KIND_ERROR, 1'b1);
            end
         endcase
      end
   endfunction

   function automatic void scan_character(input logic [7:0] c);
      token_type t;
      char_tokens.delete();
      case (scan_mode)
         MODE_WORD: begin
            if (is_alpha(c) || is_numeral(c)) append_char(c);
            else begin
               finish_word();
               scan_start(c);
            end
         end
         MODE_NUMBER: begin
            if (is_numeral(c)) append_char(c);
            else begin
               emit_token(KIND_NUMBER, 1'b1);
               scan_start(c);
            end
         end
         MODE_REL: begin
            scan_mode = MODE_IDLE;
            if (c == CH_EQ) begin
               append_char(c);
               emit_token(KIND_RELOP, 1'b1);
            end else begin
               // a bang on its own is emitted as an error token
               emit_token(lexeme_bytes[0] == CH_BANG ? KIND_ERROR : KIND_RELOP, 1'b1);
               scan_start(c);
            end
         end
         MODE_EQ: begin
            scan_mode = MODE_IDLE;
            if (c == CH_EQ) begin
               append_char(c);
               emit_token(KIND_RELOP, 1'b1);
            end else begin
               lexeme_len = 0;
               lexeme_cut = 1'b0;
               emit_token(KIND_ASSIGN, 1'b0);
               scan_start(c);
            end
         end
         default: scan_start(c);
      endcase
      if (char_tokens.size() > 0) begin
         t = char_tokens[char_tokens.size() - 1];
         t.last = 1'b1;
         char_tokens[char_tokens.size() - 1] = t;
      end
      expected_tokens = {expected_tokens, char_tokens};
   endfunction

   task automatic report_failure(input string msg);
      failure_count++;
      $display("token %0d: %s", token_count, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) report_failure($sformatf("%s expected %h got %h", name, want, got));
   endtask

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         scan_mode = MODE_IDLE;
         lexeme_len = 0;
         lexeme_cut = 1'b0;
         expected_tokens.delete();
         failure_count = 0;
         token_count = 0;
      end else begin
         if (req_valid && req_ready) scan_character(req_character);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               report_failure($sformatf("kind %0d arrived with nothing pending", rsp_kind));
            end else begin
               want = expected_tokens.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_kind));
               check_field("text_first", want.text_first, rsp_text_first);
               check_field("text_second", want.text_second, rsp_text_second);
               check_field("text_length", 64'(want.text_length), 64'(rsp_text_length));
               check_field("truncated", 64'(want.truncated), 64'(rsp_truncated));
               check_field("last", 64'(want.last), 64'(rsp_last));
            end
            token_count++;
         end
      end
      tokens_pending <= expected_tokens.size();
   end

endmodule

@@ test/tb_lexical_token_scanner.sv @@
// testbench top for the lexical token scanner: character stimulus, handshake idling and verdict
module tb_lexical_token_scanner;
   import lts_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_CHARS = 650;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_character = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_kind;
   logic [63:0] rsp_text_first;
   logic [63:0] rsp_text_second;
   logic [4:0]  rsp_text_length;
   logic        rsp_truncated;
   logic        rsp_last;

   int unsigned failure_count;
   int unsigned tokens_pending;
   int unsigned cycle_count = 0;
   int unsigned chars_sent = 0;
   int unsigned burst_left = 0;

   // receiver idling: a style held for a random stretch of cycles
   int unsigned stall_style = 0;
   int unsigned stall_left = 0;

   lexical_token_scanner dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_character   (req_character),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_text_first  (rsp_text_first),
      .rsp_text_second (rsp_text_second),
      .rsp_text_length (rsp_text_length),
      .rsp_truncated   (rsp_truncated),
      .rsp_last        (rsp_last)
   );

   // watches both channels, predicts every token and counts mismatches
   lts_token_checker token_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_character   (req_character),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_text_first  (rsp_text_first),
      .rsp_text_second (rsp_text_second),
      .rsp_text_length (rsp_text_length),
      .rsp_truncated   (rsp_truncated),
      .rsp_last        (rsp_last),
      .failure_count   (failure_count),
      .tokens_pending  (tokens_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the scanner hangs or drops a token
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lexical_token_scanner verification failed");
         $finish;
      end
   end

   // receiver: always ready, half ready, or mostly stalled, each for a random stretch
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 2);
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // one character transaction; the sender runs in bursts with idle gaps between them
   task automatic send_char(input logic [7:0] c);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // some bursts are long so that stretches with no gap occur too
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_character <= c;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // hold the sender off until every predicted token has come out
   task automatic drain_tokens();
      req_valid <= 1'b0;
      do @(posedge clock); while (tokens_pending != 0);
      burst_left = 0;
   endtask

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 1) == 1) ? 8'h61 + 8'($urandom_range(0, 25))
                                         : 8'h41 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   // mostly short lexemes, now and then one around or past the store size
   function automatic int random_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 6);
   endfunction

   function automatic logic [7:0] operator_char(input int i);
      logic [7:0] c;
      case (i)
         0: c = CH_PLUS;
         1: c = CH_MINUS;
         2: c = CH_STAR;
         3: c = CH_SLASH;
         4: c = CH_AMP;
         5: c = CH_BAR;
         6: c = CH_LBRACE;
         7: c = CH_RBRACE;
         8: c = CH_SEMI;
         9: c = CH_LPAREN;
         default: c = CH_RPAREN;
      endcase
      return c;
   endfunction

   // one random source token, mostly well formed, with noise bytes mixed in
   task automatic send_random_token();
      int pick;
      int k;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         // keyword, sometimes with a tail that turns it into an identifier
         k = $urandom_range(0, KW_COUNT - 1);
         for (int b = 0; b < KW_LEN[k]; b++) send_char(KW_TEXT[k][8*b +: 8]);
         if ($urandom_range(0, 3) == 0) begin
            n = random_length();
            for (int i = 0; i < n; i++)
               send_char($urandom_range(0, 1) ? random_letter() : random_digit());
         end
      end else if (pick < 38) begin
         n = random_length();
         send_char(random_letter());
         for (int i = 1; i < n; i++)
            send_char($urandom_range(0, 2) ? random_letter() : random_digit());
      end else if (pick < 52) begin
         n = random_length();
         for (int i = 0; i < n; i++) send_char(random_digit());
      end else if (pick < 68) begin
         send_char(operator_char($urandom_range(0, 10)));
      end else if (pick < 80) begin
         // relational operators, assignment and the lone bang
         case ($urandom_range(0, 7))
            0: send_char(CH_LT);
            1: send_char(CH_GT);
            2: send_text("<=");
            3: send_text(">=");
            4: send_text("!=");
            5: send_text("==");
            6: send_char(CH_EQ);
            default: send_char(CH_BANG);
         endcase
      end else if (pick < 92) begin
         send_char(($urandom_range(0, 2) == 0) ? CH_EOL : CH_SPACE);
      end else begin
         // any byte at all: control codes, high half, stray punctuation
         send_char(8'($urandom_range(0, 255)));
      end
      // words and numbers are often but not always followed by a space
      if (pick < 52 && $urandom_range(0, 1) == 1) send_char(CH_SPACE);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: a keyword, all six relational forms, assignment, a lone bang,
      // an invalid top byte and end of line
      send_text("do<=9>=x!=1==a<b>c=d!e");
      send_char(8'hFF);
      send_char(CH_EOL);
      drain_tokens();

      // random part, drained to empty every couple of hundred characters
      while (chars_sent < RANDOM_CHARS) begin
         send_random_token();
         if (chars_sent % 200 < 3 && chars_sent > 100) drain_tokens();
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (tokens_pending != 0);
      // idle on to catch any stray token
      repeat (10) @(posedge clock);
      if (failure_count == 0) begin
         $display("lexical_token_scanner verification clean");
      end else begin
         $display("lexical_token_scanner verification failed");
      end
      $finish;
   end

endmodule
